>>> rtl/core/tfb_pkg.sv
package tfb_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

   localparam int PIXEL_W = 32;
   localparam int DIM_W   = 10;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [PIXEL_W-1:0] BYTE_HALF_MASK = 32'h7F7F7F7F;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // transaction handed from front to back, registered alongside the frame store read data
   typedef struct packed {
      logic               valid;
      logic [PIXEL_W-1:0] pixel;
      logic               blend;
      logic               last;
   } fe_item_type;

   typedef struct packed {
      logic              room;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // per-byte floor average without carries crossing byte lanes
   function automatic logic [PIXEL_W-1:0] byte_average(input logic [PIXEL_W-1:0] a,
                                                       input logic [PIXEL_W-1:0] b);
      return (a & b) + (((a ^ b) >> 1) & BYTE_HALF_MASK);
   endfunction

endpackage

>>> rtl/core/tfb_ram.sv
module tfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             write_enable,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] write_addr,
   input  logic [WIDTH-1:0]                 write_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] read_addr,
   output logic [WIDTH-1:0]                 read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read-first: a read and write of the same address return the old word
   always_ff @(posedge clock) begin
      read_data <= mem_ff[read_addr];
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

endmodule

>>> rtl/core/tfb_front.sv
module tfb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [tfb_pkg::PIXEL_W-1:0]        pixel_in,
   input  logic                               forget,
   input  logic                               csr_write_enable,
   input  logic [tfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tfb_pkg::DIM_W-1:0]          csr_write_data,
   output tfb_pkg::fe_item_type               item,
   output logic                               ram_write_enable,
   output logic [tfb_pkg::ADDR_W-1:0]         ram_addr,
   output logic [tfb_pkg::PIXEL_W-1:0]        ram_write_data
);

   logic [tfb_pkg::DIM_W-1:0] width_ff, width_in;
   logic [tfb_pkg::DIM_W-1:0] height_ff, height_in;
   logic [tfb_pkg::COL_W-1:0] col_ff, col_in;
   logic [tfb_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      kept_valid_ff, kept_valid_in;
   logic                      blend_ff, blend_in;
   tfb_pkg::fe_item_type      item_ff, item_in;

   logic [tfb_pkg::COL_W-1:0] last_col;
   logic [tfb_pkg::ROW_W-1:0] last_row;
   logic [tfb_pkg::COL_W-1:0] col;
   logic [tfb_pkg::ROW_W-1:0] row;
   logic                      first, col_end, last;

   // clamped geometry, as last index
   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (32'(width_ff) > tfb_pkg::MAX_WIDTH) begin
         last_col = tfb_pkg::COL_W'(tfb_pkg::MAX_WIDTH - 1);
      end else begin
         last_col = tfb_pkg::COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         last_row = '0;
      end else if (32'(height_ff) > tfb_pkg::MAX_HEIGHT) begin
         last_row = tfb_pkg::ROW_W'(tfb_pkg::MAX_HEIGHT - 1);
      end else begin
         last_row = tfb_pkg::ROW_W'(height_ff - 1'b1);
      end
   end

   always_comb begin
      col     = (col_ff > last_col) ? '0 : col_ff;
      row     = (row_ff > last_row) ? '0 : row_ff;
      first   = (col == '0) && (row == '0);
      col_end = (col == last_col);
      last    = col_end && (row == last_row);
   end

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      kept_valid_in = kept_valid_ff;
      blend_in      = blend_ff;
      item_in       = '0;
      item_in.pixel = pixel_in;

      if (csr_write_enable) begin
         unique case (csr_index)
            tfb_pkg::REG_FRAME_WIDTH:  width_in  = csr_write_data;
            tfb_pkg::REG_FRAME_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
         kept_valid_in = 1'b0;
         col_in        = '0;
         row_in        = '0;
      end else if (accept) begin
         if (first) begin
            blend_in = kept_valid_ff && !forget;
         end
         item_in.valid = 1'b1;
         item_in.blend = first ? (kept_valid_ff && !forget) : blend_ff;
         item_in.last  = last;
         if (last) begin
            kept_valid_in = 1'b1;
            col_in        = '0;
            row_in        = '0;
         end else if (col_end) begin
            if (first && forget) begin
               kept_valid_in = 1'b0;
            end
            col_in = '0;
            row_in = row + 1'b1;
         end else begin
            if (first && forget) begin
               kept_valid_in = 1'b0;
            end
            col_in = col + 1'b1;
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= tfb_pkg::DIM_W'(512);
         height_ff     <= tfb_pkg::DIM_W'(512);
         col_ff        <= '0;
         row_ff        <= '0;
         kept_valid_ff <= 1'b0;
         blend_ff      <= 1'b0;
         item_ff       <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         kept_valid_ff <= kept_valid_in;
         blend_ff      <= blend_in;
         item_ff       <= item_in;
      end
   end

   assign item             = item_ff;
   assign ram_write_enable = accept && !csr_write_enable;
   assign ram_addr         = tfb_pkg::ADDR_W'(tfb_pkg::ADDR_W'(row)
                             * tfb_pkg::ADDR_W'(tfb_pkg::MAX_WIDTH))
                             + tfb_pkg::ADDR_W'(col);
   assign ram_write_data   = pixel_in;

endmodule

>>> rtl/core/tfb_back.sv
module tfb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tfb_pkg::fe_item_type          item,
   input  logic [tfb_pkg::PIXEL_W-1:0]   kept_pixel,
   input  logic                          pop,
   output tfb_pkg::queue_status_type     status,
   output logic                          empty,
   output logic [tfb_pkg::PIXEL_W-1:0]   pixel_out,
   output logic                          frame_blended,
   output logic                          frame_last
);

   typedef struct packed {
      logic [tfb_pkg::PIXEL_W-1:0] pixel;
      logic                        blend;
      logic                        last;
   } result_type;

   result_type                  queue_ff [tfb_pkg::QUEUE_DEPTH];
   logic [tfb_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tfb_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [tfb_pkg::QCNT_W-1:0]  count_ff, count_in;
   result_type                  result;
   logic                        do_pop;
   logic [tfb_pkg::QCNT_W:0]    committed;

   always_comb begin
      result.pixel = item.blend ? tfb_pkg::byte_average(item.pixel, kept_pixel) : item.pixel;
      result.blend = item.blend;
      result.last  = item.last;
   end

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = item.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + tfb_pkg::QCNT_W'(item.valid) - tfb_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item.valid) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   // slot in flight counts against the queue
   assign committed    = (tfb_pkg::QCNT_W+1)'(count_ff) + (tfb_pkg::QCNT_W+1)'(item.valid);
   assign status.room  = committed < (tfb_pkg::QCNT_W+1)'(tfb_pkg::QUEUE_DEPTH);
   assign status.count = count_ff;

   assign pixel_out     = queue_ff[rd_ptr_ff].pixel;
   assign frame_blended = queue_ff[rd_ptr_ff].blend;
   assign frame_last    = queue_ff[rd_ptr_ff].last;

endmodule

>>> rtl/core/temporal_frame_blend.sv
// Throughput: one pixel per cycle while the result queue has room; the frame store
// does one read and one write per pixel through separate ports, and a four-entry
// result queue absorbs pops.
// Reset (synchronous, active high): empty result queue, position at row 0 column 0,
// no kept frame, geometry 512 x 512. The frame store itself is not cleared.
module temporal_frame_blend (
   input  logic                               clock,
   input  logic                               reset,
   // input transactions
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [tfb_pkg::PIXEL_W-1:0]        req_pixel_in,
   input  logic                               req_forget,
   // result transactions
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [tfb_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                               rsp_frame_blended,
   output logic                               rsp_frame_last,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [tfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tfb_pkg::DIM_W-1:0]          csr_write_data
);

   tfb_pkg::fe_item_type        fe_item;
   tfb_pkg::queue_status_type   q_status;
   logic                        accept;
   logic                        ram_we;
   logic [tfb_pkg::ADDR_W-1:0]  ram_addr;
   logic [tfb_pkg::PIXEL_W-1:0] ram_wdata;
   logic [tfb_pkg::PIXEL_W-1:0] ram_rdata;

   // Back-pressure: the queue counts the transaction already in the front register,
   // so an accepted pixel always finds a slot when it reaches the queue.
   assign req_full = !q_status.room;
   assign accept   = req_push && !req_full;

   // Front: geometry, raster position, kept-frame bookkeeping and store address.
   tfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .pixel_in         (req_pixel_in),
      .forget           (req_forget),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (fe_item),
      .ram_write_enable (ram_we),
      .ram_addr         (ram_addr),
      .ram_write_data   (ram_wdata)
   );

   // Frame store: the previous frame's pixel comes out as the current one goes in.
   tfb_ram #(
      .WIDTH (tfb_pkg::PIXEL_W),
      .DEPTH (tfb_pkg::FRAME_DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_addr),
      .write_data   (ram_wdata),
      .read_addr    (ram_addr),
      .read_data    (ram_rdata)
   );

   // Back: blend against the stored pixel and queue the result.
   tfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item          (fe_item),
      .kept_pixel    (ram_rdata),
      .pop           (rsp_pop),
      .status        (q_status),
      .empty         (rsp_empty),
      .pixel_out     (rsp_pixel_out),
      .frame_blended (rsp_frame_blended),
      .frame_last    (rsp_frame_last)
   );

   // queue never overfills, including the transaction in flight
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      (32'(q_status.count) + 32'(fe_item.valid)) <= tfb_pkg::QUEUE_DEPTH)
      else $error("result queue overfilled");

   // every front transaction lands in the queue the next cycle
   a_no_loss : assert property (@(posedge clock) disable iff (reset)
      (fe_item.valid && !(rsp_pop && !rsp_empty))
      |=> (q_status.count == $past(q_status.count) + 1'b1))
      else $error("front transaction lost");

   // reset leaves nothing to pop
   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results visible after reset");

endmodule

>>> tb/sv/tb_temporal_frame_blend.sv
`timescale 1ns / 100ps

module tb_temporal_frame_blend;
   import tfb_pkg::*;

   // Run control
   localparam int CLOCK_HALF      = 10;    // 20 ns period
   localparam int RESET_CYCLES    = 9;
   localparam int DRAIN_PAUSE     = 3;
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, queue must fill
   localparam int STALL_LIMIT     = 2000;  // cycles with no transaction on either side
   localparam int RANDOM_PIXELS   = 400;

   // One output transaction as the block should present it
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               blended;
      logic               last;
   } blend_result_t;

   // DUT pins; every input is known from time zero
   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_push          = 1'b0;
   logic                   req_full;
   logic [PIXEL_W-1:0]     req_pixel_in      = '0;
   logic                   req_forget        = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop           = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_frame_blended;
   logic                   rsp_frame_last;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = REG_FRAME_WIDTH;
   logic [DIM_W-1:0]       csr_write_data    = '0;

   // Shadow of the block: frame store, position and register contents.
   // Values after reset: geometry 512 x 512, no kept frame, row 0 column 0.
   bit   [PIXEL_W-1:0]     frame_store [FRAME_DEPTH];
   logic [DIM_W-1:0]       width_reg   = DIM_W'(MAX_WIDTH);
   logic [DIM_W-1:0]       height_reg  = DIM_W'(MAX_HEIGHT);
   logic                   kept_valid  = 1'b0;
   logic                   blend_frame = 1'b0;
   logic [COL_W-1:0]       column      = '0;
   logic [ROW_W-1:0]       row         = '0;

   blend_result_t          pending_results [$];
   blend_result_t          oldest_result;
   int                     error_count = 0;

   // Sender pacing: bursts of random length separated by random gaps
   int                     burst_left = 0;
   int                     max_gap    = 2;
   int                     max_burst  = 8;

   // Receiver pacing: rotating stall pattern, plus one long hold-off on request
   bit                     hold_off_request = 1'b0;
   int                     hold_left        = 0;
   logic [15:0]            pop_pattern      = 16'hFFFF;
   int                     pattern_age      = 0;

   int                     idle_cycles = 0;

   temporal_frame_blend DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel_in      (req_pixel_in),
      .req_forget        (req_forget),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_frame_blended (rsp_frame_blended),
      .rsp_frame_last    (rsp_frame_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Register value as the block uses it: 0 behaves as 1, oversize as the maximum
   function automatic int unsigned usable_dim(input logic [DIM_W-1:0] d, input int limit);
      if (d == 0) return 1;
      if (d > limit) return limit;
      return d;
   endfunction

   // Floor average of each 8-bit channel, no carry between channels
   function automatic logic [PIXEL_W-1:0] lane_average(input logic [PIXEL_W-1:0] a,
                                                       input logic [PIXEL_W-1:0] b);
      logic [8:0]         sum;
      logic [PIXEL_W-1:0] avg;
      for (int lane = 0; lane < PIXEL_W / 8; lane++) begin
         sum = {1'b0, a[8*lane +: 8]} + {1'b0, b[8*lane +: 8]};
         avg[8*lane +: 8] = sum[8:1];
      end
      return avg;
   endfunction

   // Advances the shadow by one accepted pixel and returns the result it causes
   function automatic blend_result_t blend_pixel(input logic [PIXEL_W-1:0] pixel,
                                                 input logic forget);
      int unsigned        w;
      int unsigned        h;
      logic [ADDR_W-1:0]  addr;
      blend_result_t      res;
      w = usable_dim(width_reg, MAX_WIDTH);
      h = usable_dim(height_reg, MAX_HEIGHT);
      // forget and the blend decision only count on the first pixel of a frame
      if (column == 0 && row == 0) begin
         if (forget) kept_valid = 1'b0;
         blend_frame = kept_valid;
      end
      addr        = {row, column};
      res.pixel   = blend_frame ? lane_average(pixel, frame_store[addr]) : pixel;
      res.blended = blend_frame;
      res.last    = (column == w - 1) && (row == h - 1);
      frame_store[addr] = pixel;   // store always keeps the unblended pixel
      if (res.last) begin
         kept_valid = 1'b1;
         column     = '0;
         row        = '0;
      end else if (column == w - 1) begin
         column = '0;
         row    = row + 1'b1;
      end else begin
         column = column + 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers; all are entered just after a falling edge
   // ------------------------------------------------------------------

   // Offers one pixel transaction and waits until the block takes it.
   // req_push stays high on return so back-to-back transactions need no toggle.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic forget);
      int gap;
      if (burst_left == 0) begin
         gap        = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
         burst_left = $urandom_range(max_burst, 1);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push     <= 1'b1;
      req_pixel_in <= pixel;
      req_forget   <= forget;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_results.push_back(blend_pixel(pixel, forget));
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected result has been popped
   task automatic drain_results();
      req_push   <= 1'b0;
      burst_left  = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   // Single-cycle register write; only called with the block idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [DIM_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == REG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      // any write drops the kept frame and restarts the raster
      kept_valid = 1'b0;
      column     = '0;
      row        = '0;
      @(negedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      drain_results();
      write_register(REG_FRAME_WIDTH, DIM_W'(w));
      write_register(REG_FRAME_HEIGHT, DIM_W'(h));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset geometry 512 x 512: pass-through only, field extremes, forget at start
   task automatic test_reset_geometry();
      max_gap   = 2;
      max_burst = 4;
      send_pixel(32'h0000_0000, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h5555_5555, 1'b1);
      send_pixel(32'hAAAA_AAAA, 1'b0);
      send_pixel(32'h8000_0001, 1'b0);
      send_pixel(32'h7FFF_FFFE, 1'b0);
   endtask

   // 1 x 1 frames: every pixel is last; after the first, each blends with the previous one unless forget is set
   task automatic test_single_pixel_frames();
      set_geometry(1, 1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0000_0000, 1'b0);   // rounds down to 7F per channel
      send_pixel(32'h0101_0101, 1'b0);   // odd sum, floor to zero
      send_pixel(32'hFEFE_FEFE, 1'b1);   // forget at frame start: pass-through
      send_pixel(32'h80FF_0001, 1'b0);
   endtask

   // Forget in mid-frame is ignored; at frame start it stops blending
   task automatic test_forget_mid_frame();
      set_geometry(3, 1);
      send_pixel(32'hA5A5_A5A5, 1'b0);
      send_pixel(32'h5A5A_5A5A, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b1);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b0);
   endtask

   // Width 0 behaves as 1; rewriting an unchanged height still drops the kept frame
   task automatic test_zero_width_and_rewrite();
      set_geometry(0, 2);
      repeat (5) send_pixel($urandom, 1'b0);   // leaves the raster mid-frame
      drain_results();
      write_register(REG_FRAME_HEIGHT, DIM_W'(2));
      repeat (2) send_pixel($urandom, 1'b0);
   endtask

   // Receiver holds off for a long stretch while pixels keep coming: block fills
   task automatic test_back_pressure();
      set_geometry(4, 2);
      max_gap          = 0;
      max_burst        = 64;
      hold_off_request = 1'b1;
      repeat (40) send_pixel($urandom, 1'b0);
   endtask

   // Largest frames: oversize width clamps to one full row, oversize height to
   // one full column; the tall frame runs twice so its far corner blends
   task automatic test_extreme_geometry();
      max_gap   = 1;
      max_burst = 40;
      set_geometry(10'h3FF, 1);
      for (int k = 0; k < MAX_WIDTH + 3; k++)
         send_pixel($urandom, (k % MAX_WIDTH == 0) && ($urandom_range(3, 0) == 0));
      set_geometry(1, 10'h3FF);
      for (int k = 0; k < 2 * MAX_HEIGHT; k++)
         send_pixel($urandom, 1'b0);
   endtask

   // Runs of whole frames at random small geometries, each possibly ending in a partial frame
   task automatic test_random_frames();
      int   sent;
      int   w;
      int   h;
      int   frame_px;
      int   count;
      logic forget;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         max_gap   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         max_burst = $urandom_range(24, 1);
         w = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
         h = $urandom_range(8, 1);
         if ($urandom_range(9, 0) == 0) w = 0;
         if ($urandom_range(9, 0) == 0) h = 0;
         set_geometry(w, h);
         frame_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         count    = $urandom_range(4, 2) * frame_px + $urandom_range(frame_px - 1, 0);
         for (int k = 0; k < count; k++) begin
            // forget is more likely where it matters, but also sprinkled as noise
            if (k % frame_px == 0) forget = ($urandom_range(4, 0) == 0);
            else forget = ($urandom_range(11, 0) == 0);
            send_pixel($urandom, forget);
         end
         sent += count;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: drives rsp_pop on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left--;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left        = HOLD_OFF_CYCLES;
         rsp_pop         <= 1'b0;
      end else begin
         // fresh pattern every so often; a quarter of them never stall
         if (pattern_age == 0) begin
            if ($urandom_range(3, 0) == 0) begin
               pop_pattern = 16'hFFFF;
            end else begin
               pop_pattern = 16'($urandom);
               pop_pattern = pop_pattern | 16'h0001;
            end
            pattern_age = $urandom_range(80, 16);
         end
         pattern_age--;
         rsp_pop    <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
   end

   // ------------------------------------------------------------------
   // Result check: each popped transaction against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, pixel_out %h blended %b last %b",
                     $time, rsp_pixel_out, rsp_frame_blended, rsp_frame_last);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_pixel_out !== oldest_result.pixel) begin
               $display("%0t: pixel_out mismatch, expected %h actual %h",
                        $time, oldest_result.pixel, rsp_pixel_out);
               error_count++;
            end
            if (rsp_frame_blended !== oldest_result.blended) begin
               $display("%0t: frame_blended mismatch, expected %b actual %b",
                        $time, oldest_result.blended, rsp_frame_blended);
               error_count++;
            end
            if (rsp_frame_last !== oldest_result.last) begin
               $display("%0t: frame_last mismatch, expected %b actual %b",
                        $time, oldest_result.last, rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without a transaction on either side ends the run
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_single_pixel_frames();
      test_forget_mid_frame();
      test_zero_width_and_rewrite();
      test_back_pressure();
      test_extreme_geometry();
      test_random_frames();

      drain_results();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
